### design/cordic_atan2_fixed_top_macros.svh
// ----------------------------------------------------------------------------
// CORDIC atan2 assertion macros
// Shared concurrent assertion forms, sampled on clock, muted during reset.
// ----------------------------------------------------------------------------
`ifndef CORDIC_ATAN2_FIXED_TOP_MACROS_SVH
`define CORDIC_ATAN2_FIXED_TOP_MACROS_SVH

// implication check: antecedent, then consequent (may carry its own delay)
`define CATAN_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("catan check failed");

// invariant check
`define CATAN_ASSERT_ALWAYS(lbl, cond) \
   `CATAN_ASSERT_IMPL(lbl, 1'b1, (cond))

`endif

### design/catan_pkg.sv
// ----------------------------------------------------------------------------
// CORDIC atan2 package
// Widths, sector codes and the arctangent constant table.
// ----------------------------------------------------------------------------
package catan_pkg;

   localparam int WIDTH   = 16;               // coordinate and angle width
   localparam int GUARD   = 6;                // guard bits on the x/y datapath
   localparam int DP_W    = WIDTH + GUARD + 2;
   localparam int Z_W     = WIDTH + GUARD + 1; // angle accumulator, 21 fraction bits
   localparam int LATENCY = WIDTH + 2;        // sector stage, iterations, rounding

   localparam logic [Z_W-1:0] ROUND_BIAS = Z_W'(1) << (GUARD - 1);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // atan(2^-i)/pi, rounded to nearest at 2^-21
   function automatic logic [Z_W-1:0] atan_const(input int idx);
      logic [Z_W-1:0] c;
      case (idx)
         1:       c = Z_W'(309505);
         2:       c = Z_W'(163534);
         3:       c = Z_W'(83012);
         4:       c = Z_W'(41667);
         5:       c = Z_W'(20854);
         6:       c = Z_W'(10430);
         7:       c = Z_W'(5215);
         8:       c = Z_W'(2608);
         9:       c = Z_W'(1304);
         10:      c = Z_W'(652);
         11:      c = Z_W'(326);
         12:      c = Z_W'(163);
         13:      c = Z_W'(81);
         14:      c = Z_W'(41);
         15:      c = Z_W'(20);
         16:      c = Z_W'(10);
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

### design/cordic_atan2_fixed_top.sv
// ----------------------------------------------------------------------------
// CORDIC atan2, fixed point
// Fully pipelined vectoring CORDIC returning atan2(y,x)/pi in Q1.15.
// ----------------------------------------------------------------------------
// A coordinate word is taken at every clock edge where start is high and busy
// is low; busy is high only while reset is held, so one word per cycle is
// sustained. Each word's angle appears on rsp_angle with rsp_strobe high for
// one cycle, after one sector stage, sixteen CORDIC stages (one micro-rotation
// each) and one rounding stage. The result is not held - the receiver must
// take it in that cycle. Angle is signed, LSB 2^-15 of pi, wrapping so that
// pi reads as -1; (0,0) gives 0.
// ----------------------------------------------------------------------------
module cordic_atan2_fixed_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [catan_pkg::WIDTH-1:0]  req_x_in,
   input  logic signed [catan_pkg::WIDTH-1:0]  req_y_in,
   output logic                                rsp_strobe,
   output logic signed [catan_pkg::WIDTH-1:0]  rsp_angle
);

   localparam int W  = catan_pkg::WIDTH;
   localparam int G  = catan_pkg::GUARD;
   localparam int DW = catan_pkg::DP_W;
   localparam int ZW = catan_pkg::Z_W;

   // ------------------------------------------------------------------------
   // Pipeline registers; index 0 is the sector stage, index i holds the
   // vector after micro-rotation i.
   // ------------------------------------------------------------------------
   logic signed [DW-1:0] cx_ff   [0:W];
   logic signed [DW-1:0] cy_ff   [0:W];
   logic signed [ZW-1:0] z_ff    [0:W];
   logic [1:0]           quad_ff [0:W];
   logic                 zero_ff [0:W];
   logic                 vld_ff  [0:W];

   logic                 rsp_strobe_ff;
   logic [W-1:0]         rsp_angle_ff;

   // Never stalls; only held off during reset.
   assign busy = reset;

   // ------------------------------------------------------------------------
   // Sector choice and coarse quarter turn
   // ------------------------------------------------------------------------
   logic signed [W:0]    sum_xy;
   logic                 lt, nn;
   logic [1:0]           quad_in;
   logic signed [DW-1:0] px, py;
   logic signed [DW-1:0] cx0_in, cy0_in;
   logic                 zero_in;
   logic                 take;

   assign take    = start && !busy;
   assign sum_xy  = {req_x_in[W-1], req_x_in} + {req_y_in[W-1], req_y_in};
   assign lt      = req_x_in < req_y_in;
   assign nn      = !sum_xy[W];
   assign zero_in = (req_x_in == '0) && (req_y_in == '0);

   // coordinates padded with guard bits, sign extended by two
   assign px = {{2{req_x_in[W-1]}}, req_x_in, {G{1'b0}}};
   assign py = {{2{req_y_in[W-1]}}, req_y_in, {G{1'b0}}};

   always_comb begin
      if (!req_x_in[W-1] && !lt && nn) begin
         quad_in = catan_pkg::QUAD_0;
      end else if (!req_y_in[W-1] && lt && nn) begin
         quad_in = catan_pkg::QUAD_1;
      end else if (req_x_in[W-1] && lt && !nn) begin
         quad_in = catan_pkg::QUAD_2;
      end else begin
         quad_in = catan_pkg::QUAD_3;
      end
   end

   // negation as plain complement: one guard ulp low, matches the datapath
   always_comb begin
      case (quad_in)
         catan_pkg::QUAD_0: begin
            cx0_in = px;
            cy0_in = py;
         end
         catan_pkg::QUAD_1: begin
            cx0_in = py;
            cy0_in = ~px;
         end
         catan_pkg::QUAD_2: begin
            cx0_in = ~px;
            cy0_in = ~py;
         end
         default: begin        // fourth quadrant
            cx0_in = ~py;
            cy0_in = px;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= take;
      end
      cx_ff[0]   <= cx0_in;
      cy_ff[0]   <= cy0_in;
      z_ff[0]    <= '0;
      quad_ff[0] <= quad_in;
      zero_ff[0] <= zero_in;
   end

   // ------------------------------------------------------------------------
   // Vectoring stages: drive y towards zero, accumulate the angle in z.
   // Shifts are arithmetic (floor); one add/sub per coordinate per stage.
   // ------------------------------------------------------------------------
   for (genvar s = 1; s <= W; s++) begin : g_iter
      logic signed [DW-1:0] cx_in, cy_in;
      logic signed [ZW-1:0] z_in;
      logic signed [ZW-1:0] step;

      assign step = $signed(catan_pkg::atan_const(s));

      always_comb begin
         if (!cy_ff[s-1][DW-1]) begin
            // y non-negative: turn clockwise
            cx_in = cx_ff[s-1] + (cy_ff[s-1] >>> s);
            cy_in = cy_ff[s-1] - (cx_ff[s-1] >>> s);
            z_in  = z_ff[s-1] + step;
         end else begin
            cx_in = cx_ff[s-1] - (cy_ff[s-1] >>> s);
            cy_in = cy_ff[s-1] + (cx_ff[s-1] >>> s);
            z_in  = z_ff[s-1] - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_ff[s-1];
         end
         cx_ff[s]   <= cx_in;
         cy_ff[s]   <= cy_in;
         z_ff[s]    <= z_in;
         quad_ff[s] <= quad_ff[s-1];
         zero_ff[s] <= zero_ff[s-1];
      end
   end

   // ------------------------------------------------------------------------
   // Rounding: drop guard bits (nearest, ties up), add the quarter turn.
   // Sum wraps modulo 2^W; the origin gives 0.
   // ------------------------------------------------------------------------
   logic [ZW-1:0] z_rnd;
   logic [W-1:0]  angle_in;

   assign z_rnd = z_ff[W] + catan_pkg::ROUND_BIAS;

   always_comb begin
      if (zero_ff[W]) begin
         angle_in = '0;
      end else begin
         angle_in = {quad_ff[W], {(W-2){1'b0}}} + z_rnd[G +: W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[W];
      end
      rsp_angle_ff <= angle_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_angle  = $signed(rsp_angle_ff);

endmodule

### design/catan_checker.sv
// ----------------------------------------------------------------------------
// CORDIC atan2 port checker
// Port-level checks on throughput, fixed latency and the origin case.
// ----------------------------------------------------------------------------
`include "cordic_atan2_fixed_top_macros.svh"

module catan_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic signed [catan_pkg::WIDTH-1:0]  req_x_in,
   input logic signed [catan_pkg::WIDTH-1:0]  req_y_in,
   input logic                                rsp_strobe,
   input logic signed [catan_pkg::WIDTH-1:0]  rsp_angle
);

   // busy only while reset is held, so a word is accepted every cycle outside it
   `CATAN_ASSERT_ALWAYS(a_never_busy, busy == reset)

   // every taken word gives exactly one strobe, a fixed time later
   `CATAN_ASSERT_IMPL(a_latency, start && !busy, ##(catan_pkg::LATENCY) rsp_strobe)

   // no strobe without a word taken that far back
   `CATAN_ASSERT_IMPL(a_no_spurious, rsp_strobe, $past(start && !busy, catan_pkg::LATENCY))

   // origin gives a zero angle
   `CATAN_ASSERT_IMPL(a_origin, start && !busy && req_x_in == '0 && req_y_in == '0, ##(catan_pkg::LATENCY) (rsp_angle == '0))

endmodule

bind cordic_atan2_fixed_top catan_checker u_catan_checker (.*);

### test/cordic_atan2_fixed_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CORDIC atan2 testbench
// Streams coordinate words into the pipelined atan2 block. A bit-exact
// predictor scores every angle word that comes back, in order.
// ----------------------------------------------------------------------------
module cordic_atan2_fixed_top_tb;

   localparam int W           = catan_pkg::WIDTH;
   localparam int N_RANDOM    = 1250;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN       = catan_pkg::LATENCY + 8;

   localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
   } coord_type;

   typedef struct packed {
      coord_type           c;
      logic signed [W-1:0] angle;
   } angle_exp_type;

   logic                clock    = 1'b0;
   logic                reset    = 1'b1;
   logic                start    = 1'b0;
   logic signed [W-1:0] req_x_in = '0;
   logic signed [W-1:0] req_y_in = '0;
   logic                busy;
   logic                rsp_strobe;
   logic signed [W-1:0] rsp_angle;

   cordic_atan2_fixed_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_x_in   (req_x_in),
      .req_y_in   (req_y_in),
      .rsp_strobe (rsp_strobe),
      .rsp_angle  (rsp_angle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor. Constants are computed here, independent of the package
   // table.
   // ---------------------------------------------------------------------
   longint atan_units [1:W];   // atan(2^-i)/pi in accumulator ulps
   int     guard_w;            // guard bits on the x/y path

   function automatic void build_atan_units();
      real pi_r;
      real eps;
      real v;
      int  n;
      pi_r = 4.0 * $atan(1.0);
      // error bound of the truncated iterations sets the guard width
      eps = 2.0;
      for (int s = 1; s <= W; s++)
         eps = eps + eps / real'(longint'(1) << s) + 1.0;
      eps = eps + 1.0;
      n = 0;
      while (n < 20 && real'(longint'(1) << n) < eps)
         n++;
      guard_w = 1 + n;
      for (int s = 1; s <= W; s++) begin
         v = $atan(1.0 / real'(longint'(1) << s)) / pi_r
             * real'(longint'(1) << (W + guard_w - 1));
         atan_units[s] = longint'($floor(v + 0.5));
      end
   endfunction

   function automatic logic signed [W-1:0] atan2_angle(input logic signed [W-1:0] xi,
                                                       input logic signed [W-1:0] yi);
      longint     x;
      longint     y;
      longint     cx;
      longint     cy;
      longint     nx;
      longint     ny;
      longint     z;
      longint     pad;
      longint     r;
      logic [1:0] quad;
      logic       lt;
      logic       nn;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0)
         return '0;
      lt = x < y;
      nn = (x + y) >= 0;
      if (x >= 0 && !lt && nn)
         quad = catan_pkg::QUAD_0;
      else if (y >= 0 && lt && nn)
         quad = catan_pkg::QUAD_1;
      else if (x < 0 && lt && !nn)
         quad = catan_pkg::QUAD_2;
      else
         quad = catan_pkg::QUAD_3;
      // negation on the padded value is a plain complement, one guard ulp off
      pad = longint'(1) << guard_w;
      case (quad)
         catan_pkg::QUAD_0: begin cx = x * pad;      cy = y * pad;      end
         catan_pkg::QUAD_1: begin cx = y * pad;      cy = -(x * pad) - 1; end
         catan_pkg::QUAD_2: begin cx = -(x * pad) - 1; cy = -(y * pad) - 1; end
         default:           begin cx = -(y * pad) - 1; cy = x * pad;      end
      endcase
      for (int s = 1; s <= W; s++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> s);
            ny = cy - (cx >>> s);
            z  = z + atan_units[s];
         end else begin
            nx = cx - (cy >>> s);
            ny = cy + (cx >>> s);
            z  = z - atan_units[s];
         end
         cx = nx;
         cy = ny;
      end
      r = (z + (longint'(1) << (guard_w - 1))) >>> guard_w;
      return W'((longint'(quad) << (W - 2)) + r);
   endfunction

   // ---------------------------------------------------------------------
   // Stores shared by driver, monitor and sequencer
   // ---------------------------------------------------------------------
   coord_type     coord_words[$];     // words still to be sent
   angle_exp_type pending_angles[$];  // predicted angles, oldest first
   int            n_items    = 0;
   int            n_taken    = 0;
   int            mismatches = 0;

   // ---------------------------------------------------------------------
   // Driver: presents words from coord_words, predicts each one taken.
   // Sender gap rate: 25 % for the first third, 51 % for the second,
   // none for the last third (back-to-back words).
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      coord_type nxt;
      int        idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pending_angles.push_back('{c: '{x: req_x_in, y: req_y_in},
                                       angle: atan2_angle(req_x_in, req_y_in)});
            n_taken++;
         end
         // word still waiting on busy: hold it as is
         if (!(start && busy)) begin
            if (n_taken < n_items / 3)
               idle_pct = 25;
            else if (n_taken < (2 * n_items) / 3)
               idle_pct = 51;
            else
               idle_pct = 0;
            if (coord_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
               nxt = coord_words.pop_front();
               req_x_in <= nxt.x;
               req_y_in <= nxt.y;
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: the strobe lasts one cycle and cannot be stalled, so every
   // strobed cycle is scored against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      angle_exp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected angle word %0d, nothing pending", rsp_angle);
         end else begin
            want = pending_angles.pop_front();
            if (rsp_angle !== want.angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("angle mismatch x=%0d y=%0d: expected %0d, got %0d",
                           want.c.x, want.c.y, want.angle, rsp_angle);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic add_word(input logic signed [W-1:0] xv, input logic signed [W-1:0] yv);
      coord_words.push_back('{x: xv, y: yv});
   endtask

   function automatic logic signed [W-1:0] small_coord();
      return W'(int'($urandom_range(16)) - 8);
   endfunction

   function automatic logic signed [W-1:0] extreme_coord();
      case ($urandom_range(4))
         0:       return CMIN;
         1:       return CMAX;
         2:       return '0;
         3:       return W'(1);
         default: return W'(-1);
      endcase
   endfunction

   initial begin : sequencer
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] t;
      int                  d;
      build_atan_units();

      // directed: origin, axes and corners at full scale
      add_word(0, 0);
      add_word(CMAX, 0);
      add_word(CMIN, 0);      // exactly pi, reads back as -1
      add_word(0, CMAX);
      add_word(0, CMIN);
      add_word(CMAX, CMAX);
      add_word(CMIN, CMIN);
      add_word(CMAX, CMIN);
      add_word(CMIN, CMAX);
      // tiny vectors, where the truncated iterations are coarse
      add_word(1, 0);
      add_word(0, 1);
      add_word(-1, 0);
      add_word(0, -1);
      add_word(1, 1);
      add_word(-1, -1);
      add_word(1, -1);
      add_word(-1, 1);
      // sector boundaries on the diagonals
      add_word(1000, 1000);
      add_word(-1000, 1000);
      add_word(-1000, -1000);
      add_word(1000, -1000);
      // either side of the wrap at pi
      add_word(-20000, 1);
      add_word(-20000, -1);

      for (int i = 0; i < N_RANDOM; i++) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               x = W'($urandom);
               y = W'($urandom);
            end
            5: begin
               x = small_coord();
               y = small_coord();
            end
            6: begin
               // on or next to a diagonal
               x = W'($urandom);
               d = int'($urandom_range(2)) - 1;
               y = $urandom_range(1) ? W'(x + d) : W'(-x + d);
            end
            7: begin
               // near an axis
               x = W'($urandom);
               y = small_coord();
               if ($urandom_range(1)) begin
                  t = x;
                  x = y;
                  y = t;
               end
            end
            8: begin
               x = W'(int'($urandom_range(1024)) - 512);
               y = W'(int'($urandom_range(1024)) - 512);
            end
            default: begin
               x = extreme_coord();
               y = extreme_coord();
            end
         endcase
         add_word(x, y);
      end
      n_items = coord_words.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (n_taken < n_items)
         @(posedge clock);
      while (pending_angles.size() != 0)
         @(posedge clock);
      // catch any stray strobe behind the last word
      repeat (DRAIN) @(posedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog: a hung pipe or lost strobe ends here
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
